>>> sv/ubesc_pkg.sv
// shared types, constants and decode helpers for the utf-8 escaper
`timescale 1ns / 1ps

package ubesc_pkg;

	localparam int CFG_W           = 16;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int PTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	// unit kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NONE = 2'd0;
	localparam kind_t KIND_PASS = 2'd1;
	localparam kind_t KIND_HEX2 = 2'd2;
	localparam kind_t KIND_HEX4 = 2'd3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	typedef logic [3:0][7:0] work_t;

	typedef struct packed {
		logic        stop;
		kind_t       kind;
		logic [2:0]  nb;
		logic [2:0]  len;
		logic [31:0] data;
	} cls_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  nb;
		logic [31:0] data;
		logic        clr;
		logic        last;
	} unit_t;

	function automatic logic is_bidi(input logic [20:0] cp);
		return cp == 21'h0061C || cp == 21'h0200E || cp == 21'h0200F ||
			(cp >= 21'h0202A && cp <= 21'h0202E) ||
			(cp >= 21'h02066 && cp <= 21'h02069);
	endfunction

	// decode the unit at the front of the work buffer
	function automatic cls_t classify(input work_t w, input logic [2:0] n, input logic eor);
		cls_t c;
		logic [7:0] b0;
		logic [2:0] need;
		logic [2:0] upto;
		logic ok;
		logic [20:0] cp;
		c = '0;
		b0 = w[0];
		ok = 1'b1;
		cp = '0;
		if (b0 >= LEAD2_LO && b0 <= 8'hDF) need = 3'd2;
		else if (b0 >= 8'hE0 && b0 <= 8'hEF) need = 3'd3;
		else if (b0 >= 8'hF0 && b0 <= LEAD4_HI) need = 3'd4;
		else need = 3'd0;
		upto = (n < need) ? n : need;
		for (int i = 1; i < 4; i++) begin
			if (3'(i) < upto) begin
				if (w[i] < 8'h80 || w[i] > 8'hBF) ok = 1'b0;
				if (i == 1) begin
					if (b0 == 8'hE0 && w[i] < 8'hA0) ok = 1'b0;
					if (b0 == 8'hED && w[i] > 8'h9F) ok = 1'b0;
					if (b0 == 8'hF0 && w[i] < 8'h90) ok = 1'b0;
					if (b0 == LEAD4_HI && w[i] > 8'h8F) ok = 1'b0;
				end
			end
		end
		unique case (need)
			3'd2: cp = {10'b0, b0[4:0], w[1][5:0]};
			3'd3: cp = {5'b0, b0[3:0], w[1][5:0], w[2][5:0]};
			3'd4: cp = {b0[2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
			default: cp = '0;
		endcase
		if (n == 3'd0) begin
			c.stop = 1'b1;
		end else if (b0 < 8'h80) begin
			c.len = 3'd1;
			if (b0 == CH_TAB || (b0 >= CH_SPACE && b0 < CH_DEL)) begin
				c.kind = KIND_PASS;
				c.nb   = 3'd1;
				c.data = w;
			end else begin
				c.kind = KIND_HEX2;
				c.nb   = 3'd4;
				c.data = {24'b0, b0};
			end
		end else if (need != 3'd0 && ok && n >= need) begin
			c.len = need;
			if ((cp >= 21'h80 && cp <= 21'h9F) || is_bidi(cp)) begin
				c.kind = KIND_HEX4;
				c.nb   = 3'd6;
				c.data = {16'b0, cp[15:0]};
			end else begin
				c.kind = KIND_PASS;
				c.nb   = need;
				c.data = w;
			end
		end else if (need != 3'd0 && ok && !eor) begin
			// incomplete but still valid prefix: stays pending
			c.stop = 1'b1;
		end else begin
			c.len  = 3'd1;
			c.kind = KIND_HEX2;
			c.nb   = 3'd4;
			c.data = {24'b0, b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'b0, v}) : (8'h37 + {4'b0, v});
	endfunction

	// byte number idx of a unit's output text
	function automatic logic [7:0] unit_byte(input kind_t k, input logic [31:0] d,
			input logic [2:0] idx);
		logic [7:0] b;
		b = '0;
		unique case (k)
			KIND_PASS: b = d[{idx[1:0], 3'b000} +: 8];
			KIND_HEX2: begin
				unique case (idx)
					3'd0: b = CH_BSL;
					3'd1: b = CH_X;
					3'd2: b = hex_char(d[7:4]);
					default: b = hex_char(d[3:0]);
				endcase
			end
			KIND_HEX4: begin
				unique case (idx)
					3'd0: b = CH_BSL;
					3'd1: b = CH_U;
					3'd2: b = hex_char(d[15:12]);
					3'd3: b = hex_char(d[11:8]);
					3'd4: b = hex_char(d[7:4]);
					default: b = hex_char(d[3:0]);
				endcase
			end
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

>>> sv/ubesc_fifo.sv
// short unit queue between the decode front and the output back
`timescale 1ns / 1ps

module ubesc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ubesc_pkg::unit_t push_data,
	output logic             full,
	input  logic             pop,
	output ubesc_pkg::unit_t head,
	output logic             head_valid
);
	import ubesc_pkg::*;

	unit_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> sv/ubesc_front.sv
// front: accepts bytes, keeps the pending sequence and splits the text into units
`timescale 1ns / 1ps

module ubesc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	input  logic             end_of_run,
	input  logic             line_start,
	output logic             push,
	output ubesc_pkg::unit_t push_data,
	input  logic             full
);
	import ubesc_pkg::*;

	logic             busy_q;
	work_t            work_q;
	logic [2:0]       n_q;
	logic             eor_q;
	logic [2:0][7:0]  pend_q;
	logic [1:0]       pcnt_q;

	work_t      cur_w;
	logic [2:0] cur_n;
	logic       cur_eor;
	cls_t       cls;
	work_t      sh_w;
	logic [2:0] sh_n;
	cls_t       cls2;
	logic       fire;

	// idle: pending bytes followed by the new byte
	always_comb begin
		cur_w   = work_q;
		cur_n   = n_q;
		cur_eor = eor_q;
		if (!busy_q) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < pcnt_q) cur_w[i] = pend_q[i];
				else if (2'(i) == pcnt_q) cur_w[i] = data_byte;
				else cur_w[i] = '0;
			end
			cur_w[3] = (pcnt_q == 2'd3) ? data_byte : 8'h00;
			cur_n    = {1'b0, pcnt_q} + 3'd1;
			cur_eor  = end_of_run;
		end
	end

	assign cls  = classify(cur_w, cur_n, cur_eor);
	assign sh_w = cur_w >> {cls.len, 3'b000};
	assign sh_n = cur_n - cls.len;
	// look one unit ahead so the unit that closes the item carries last
	assign cls2 = classify(sh_w, sh_n, cur_eor);

	assign in_ready = !busy_q && !full;
	assign fire     = (busy_q || in_valid) && !full;
	assign push     = fire;

	always_comb begin
		push_data.kind = cls.kind;
		push_data.nb   = cls.nb;
		push_data.data = cls.data;
		push_data.clr  = !busy_q && line_start;
		push_data.last = cls.stop || cls2.stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pcnt_q <= '0;
		end else if (fire) begin
			if (cls.stop) begin
				busy_q <= 1'b0;
				pcnt_q <= cur_n[1:0];
			end else if (cls2.stop) begin
				busy_q <= 1'b0;
				pcnt_q <= sh_n[1:0];
			end else begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cls.stop) pend_q <= cur_w[2:0];
			else if (cls2.stop) pend_q <= sh_w[2:0];
			work_q <= sh_w;
			n_q    <= sh_n;
			eor_q  <= cur_eor;
		end
	end

endmodule

>>> sv/ubesc_back.sv
// back: column budget and byte-by-byte output of each unit
`timescale 1ns / 1ps

module ubesc_back #(
	parameter int COLUMN_BITS = ubesc_pkg::COLUMN_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [ubesc_pkg::CFG_W-1:0] cfg_data,
	input  ubesc_pkg::unit_t            head,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        last_of_item
);
	import ubesc_pkg::*;

	logic [COLUMN_BITS-1:0] lim_q;
	logic [COLUMN_BITS:0]   cnt_q;
	logic [2:0]             idx_q;
	logic                   lastu_q;
	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic                   out_last_q;

	logic [COLUMN_BITS-1:0] lim_wr;
	logic [COLUMN_BITS:0]   cnt_eff;
	logic [COLUMN_BITS:0]   new_cnt;
	logic                   lim_on;
	logic                   start;
	logic                   skip;
	logic                   adv;
	logic                   emit;
	logic                   lastu;
	logic                   end_unit;

	generate
		if (COLUMN_BITS > CFG_W) begin : g_wide
			assign lim_wr = {{(COLUMN_BITS - CFG_W){1'b0}}, cfg_data};
		end else if (COLUMN_BITS == CFG_W) begin : g_same
			assign lim_wr = cfg_data;
		end else begin : g_narrow
			assign lim_wr = cfg_data[COLUMN_BITS-1:0];
		end
	endgenerate

	assign lim_on  = lim_q != '0;
	assign cnt_eff = head.clr ? '0 : cnt_q;
	assign new_cnt = cnt_eff + (COLUMN_BITS + 1)'(head.nb);
	assign start   = head_valid && idx_q == 3'd0;
	// budget used up or empty unit: unit is consumed without output
	assign skip    = head.kind == KIND_NONE || (lim_on && cnt_eff >= {1'b0, lim_q});
	assign adv     = !out_valid_q || out_ready;
	assign emit    = head_valid && adv && !(start && skip);
	// once the budget is hit every later unit of the item drops, so this byte closes it
	assign lastu   = (idx_q == 3'd0)
		? (head.last || (lim_on && new_cnt >= {1'b0, lim_q})) : lastu_q;
	assign end_unit = idx_q == head.nb - 3'd1;
	assign pop      = (start && skip) || (emit && end_unit);

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			lastu_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) lim_q <= lim_wr;
			if (start && skip) begin
				cnt_q <= cnt_eff;
			end else if (emit) begin
				if (idx_q == 3'd0) begin
					cnt_q   <= new_cnt;
					lastu_q <= lastu;
				end
				idx_q <= end_unit ? 3'd0 : idx_q + 3'd1;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= unit_byte(head.kind, head.data, idx_q);
			out_last_q <= lastu && end_unit;
		end
	end

endmodule

>>> sv/utf8_control_bidi_escaper_unit.sv
// top level of the utf-8 validating control and bidi escaper
`timescale 1ns / 1ps

// channel   signals                                          direction
// input     in_valid, in_ready, data_byte, end_of_run,       in
//           line_start
// output    out_valid, out_ready, out_byte, last_of_item     out
// config    cfg_valid, cfg_ready, column_limit               in
//
// the front takes one byte per cycle unless busy or the queue is full; a broken
// sequence splits into up to four units, decoded in turn with no new byte taken.
// the back sends one byte per cycle while out_ready allows: 1 to 4 for a plain
// character, 4 for \xNN, 6 for \uNNNN, nothing for a dropped unit or an extending byte.
// a four-entry unit queue lets either side stall alone; output is registered.
// reset clears the pending count, column counter and limit; no clearing pass.

module utf8_control_bidi_escaper_unit #(
	parameter int COLUMN_BITS = ubesc_pkg::COLUMN_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        end_of_run,
	input  logic                        line_start,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        last_of_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ubesc_pkg::CFG_W-1:0] column_limit
);
	import ubesc_pkg::*;

	unit_t push_data;
	unit_t head;
	logic  push;
	logic  full;
	logic  pop;
	logic  head_valid;

	assign cfg_ready = 1'b1;

	ubesc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.end_of_run (end_of_run),
		.line_start (line_start),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	ubesc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	ubesc_back #(
		.COLUMN_BITS (COLUMN_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (column_limit),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

endmodule
